FILE: rtl/brusselator_cell_euler_update_macros.svh
// Assertion macros shared by the RTL of the Brusselator cell update.
// No dependencies; include by bare file name where assertions are written.
`ifndef BRUSSELATOR_CELL_EULER_UPDATE_MACROS_SVH
`define BRUSSELATOR_CELL_EULER_UPDATE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BCE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bce: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define BCE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bce: next-cycle check failed");

`endif

FILE: rtl/bce_pkg.sv
// Package for the Brusselator cell update: Q8.24 types, register codes,
// reset values and the saturating fixed-point helpers. No dependencies.
`default_nettype none

package bce_pkg;

    localparam int QW       = 32;
    localparam int FRAC     = 24;
    localparam int WIDE     = 40;
    localparam int SUMW     = 34;
    localparam int CFG_IW   = 3;
    localparam int NSTG     = 5;

    typedef logic signed [QW-1:0]   t_q;
    typedef logic        [QW-2:0]   t_uq;
    typedef logic signed [WIDE-1:0] t_wide;
    typedef logic signed [SUMW-1:0] t_sum;

    typedef enum logic [CFG_IW-1:0] {
        CFG_FEED_A          = 3'd0,
        CFG_FEED_B          = 3'd1,
        CFG_TIME_STEP       = 3'd2,
        CFG_COUPLING        = 3'd3,
        CFG_DIFF_GAIN_ONE   = 3'd4,
        CFG_DIFF_GAIN_TWO   = 3'd5,
        CFG_DIFF_GAIN_THREE = 3'd6
    } t_cfg_idx;

    localparam t_q  RST_FEED_A      = 32'sd18119393;
    localparam t_q  RST_FEED_B      = 32'sd51673825;
    localparam t_uq RST_TIME_STEP   = 31'd8389;
    localparam t_uq RST_COUPLING    = 31'd0;
    localparam t_uq RST_GAIN_ONE    = 31'd21475;
    localparam t_uq RST_GAIN_TWO    = 31'd214748;
    localparam t_uq RST_GAIN_THREE  = 31'd2147484;

    // 2.0 in Q8.24
    localparam t_wide Q_TWO = t_wide'(1) <<< (FRAC + 1);

    typedef struct packed {
        t_q   val;
        logic ovf;
    } t_satq;

    function automatic t_wide sx(input t_q v);
        return t_wide'(v);
    endfunction

    function automatic t_q uq(input t_uq v);
        return t_q'({1'b0, v});
    endfunction

    function automatic t_satq sat40(input t_wide v);
        t_satq r;
        r.ovf = 1'b1;
        if (v > sx(t_q'({1'b0, {(QW-1){1'b1}}}))) begin
            r.val = t_q'({1'b0, {(QW-1){1'b1}}});
        end else if (v < sx(t_q'({1'b1, {(QW-1){1'b0}}}))) begin
            r.val = t_q'({1'b1, {(QW-1){1'b0}}});
        end else begin
            r.val = v[QW-1:0];
            r.ovf = 1'b0;
        end
        return r;
    endfunction

    // Q8.24 product, round half up, saturate
    function automatic t_satq mulq(input t_q x, input t_q y);
        logic signed [2*QW-1:0] xe;
        logic signed [2*QW-1:0] ye;
        logic signed [2*QW-1:0] p;
        xe = (2*QW)'(x);
        ye = (2*QW)'(y);
        p  = xe * ye + ((2*QW)'(1) <<< (FRAC - 1));
        return sat40($signed(p[2*QW-1:FRAC]));
    endfunction

endpackage

`default_nettype wire

FILE: rtl/bce_if.sv
// Stream and register-write interfaces of the Brusselator cell update.
// Depends on bce_pkg.
`default_nettype none

interface bce_in_if import bce_pkg::*; ();
    logic valid;
    logic ready;
    t_q   conc_one;
    t_q   conc_two;
    t_q   conc_three;
    t_q   one_left;
    t_q   one_right;
    t_q   two_left;
    t_q   two_right;
    t_q   three_left;
    t_q   three_right;
    t_q   one_delayed_other;
    t_q   two_delayed_other;
    t_q   three_delayed_other;

    modport source (
        output valid, conc_one, conc_two, conc_three, one_left, one_right,
               two_left, two_right, three_left, three_right,
               one_delayed_other, two_delayed_other, three_delayed_other,
        input  ready
    );
    modport sink (
        input  valid, conc_one, conc_two, conc_three, one_left, one_right,
               two_left, two_right, three_left, three_right,
               one_delayed_other, two_delayed_other, three_delayed_other,
        output ready
    );
endinterface

interface bce_out_if import bce_pkg::*; ();
    logic valid;
    logic ready;
    t_q   next_one;
    t_q   next_two;
    t_q   next_three;
    logic overflow;

    modport source (output valid, next_one, next_two, next_three, overflow, input ready);
    modport sink   (input  valid, next_one, next_two, next_three, overflow, output ready);
endinterface

interface bce_cfg_if import bce_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CFG_IW-1:0] index;
    logic [QW-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input  valid, index, data, output ready);
endinterface

`default_nettype wire

FILE: rtl/brusselator_cell_euler_update.sv
// Brusselator cell update: one explicit Euler step of three species, Q8.24.
// Depends on bce_pkg, bce_if.sv and brusselator_cell_euler_update_macros.svh.
//
//  port    dir  carries
//  i_in    in   cell, neighbour and delayed concentrations (request per cell)
//  o_out   out  next concentrations and overflow flag
//  i_cfg   in   register writes (index, data), always ready
//
// Five register stages; one cell accepted per cycle while the output is not stalled.
// Each stage holds one level of multiplies with their rounding and saturation,
// sums, or both; the final stage is the output register.
// Stalls back up through a per-stage ready chain; bubbles are squeezed out.
// Reset clears the stage valid bits and loads the register reset values.
`default_nettype none

`include "brusselator_cell_euler_update_macros.svh"

module brusselator_cell_euler_update import bce_pkg::*; (
    input  wire       i_clk,
    input  wire       i_rst_n,
    bce_in_if.sink    i_in,
    bce_out_if.source o_out,
    bce_cfg_if.sink   i_cfg
);

    // configuration
    t_q  r_feed_a, r_feed_b;
    t_uq r_dt, r_ep, r_g1, r_g2, r_g3;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_feed_a <= RST_FEED_A;
            r_feed_b <= RST_FEED_B;
            r_dt     <= RST_TIME_STEP;
            r_ep     <= RST_COUPLING;
            r_g1     <= RST_GAIN_ONE;
            r_g2     <= RST_GAIN_TWO;
            r_g3     <= RST_GAIN_THREE;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_FEED_A:          r_feed_a <= t_q'(i_cfg.data);
                CFG_FEED_B:          r_feed_b <= t_q'(i_cfg.data);
                CFG_TIME_STEP:       r_dt     <= i_cfg.data[QW-2:0];
                CFG_COUPLING:        r_ep     <= i_cfg.data[QW-2:0];
                CFG_DIFF_GAIN_ONE:   r_g1     <= i_cfg.data[QW-2:0];
                CFG_DIFF_GAIN_TWO:   r_g2     <= i_cfg.data[QW-2:0];
                CFG_DIFF_GAIN_THREE: r_g3     <= i_cfg.data[QW-2:0];
                default: ;
            endcase
        end
    end

    // handshake chain
    logic [NSTG-1:0] r_vld;
    logic [NSTG-1:0] stg_rdy;
    logic [NSTG-1:0] ld;

    always_comb begin
        stg_rdy[NSTG-1] = !r_vld[NSTG-1] || o_out.ready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            stg_rdy[k] = !r_vld[k] || stg_rdy[k+1];
        end
        ld[0] = stg_rdy[0] && i_in.valid;
        for (int k = 1; k < NSTG; k++) begin
            ld[k] = stg_rdy[k] && r_vld[k-1];
        end
    end

    assign i_in.ready = stg_rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stg_rdy[0]) r_vld[0] <= i_in.valid;
            for (int k = 1; k < NSTG; k++) begin
                if (stg_rdy[k]) r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // stage 1: u1^2, b*u1, 2+b, Dt*ep, u1-u3, laplacians, coupling differences
    t_satq n1_sq, n1_bu1, n1_twob, n1_dtep, n1_re3;
    t_satq n1_lap1, n1_lap2, n1_lap3, n1_dif1, n1_dif2, n1_dif3;
    t_q    r1_sq, r1_bu1, r1_twob, r1_dtep, r1_re3;
    t_q    r1_lap1, r1_lap2, r1_lap3, r1_dif1, r1_dif2, r1_dif3;
    t_q    r1_u1, r1_u2, r1_u3;
    logic  r1_ovf;

    always_comb begin
        n1_sq   = mulq(i_in.conc_one, i_in.conc_one);
        n1_bu1  = mulq(r_feed_b, i_in.conc_one);
        n1_twob = sat40(Q_TWO + sx(r_feed_b));
        n1_dtep = mulq(uq(r_dt), uq(r_ep));
        n1_re3  = sat40(sx(i_in.conc_one) - sx(i_in.conc_three));
        n1_lap1 = sat40(sx(i_in.one_right) + sx(i_in.one_left) - (sx(i_in.conc_one) <<< 1));
        n1_lap2 = sat40(sx(i_in.two_right) + sx(i_in.two_left) - (sx(i_in.conc_two) <<< 1));
        n1_lap3 = sat40(sx(i_in.three_right) + sx(i_in.three_left)
                        - (sx(i_in.conc_three) <<< 1));
        n1_dif1 = sat40(sx(i_in.one_delayed_other) - sx(i_in.conc_one));
        n1_dif2 = sat40(sx(i_in.two_delayed_other) - sx(i_in.conc_two));
        n1_dif3 = sat40(sx(i_in.three_delayed_other) - sx(i_in.conc_three));
    end

    always_ff @(posedge i_clk) begin
        if (ld[0]) begin
            r1_sq   <= n1_sq.val;
            r1_bu1  <= n1_bu1.val;
            r1_twob <= n1_twob.val;
            r1_dtep <= n1_dtep.val;
            r1_re3  <= n1_re3.val;
            r1_lap1 <= n1_lap1.val;
            r1_lap2 <= n1_lap2.val;
            r1_lap3 <= n1_lap3.val;
            r1_dif1 <= n1_dif1.val;
            r1_dif2 <= n1_dif2.val;
            r1_dif3 <= n1_dif3.val;
            r1_u1   <= i_in.conc_one;
            r1_u2   <= i_in.conc_two;
            r1_u3   <= i_in.conc_three;
            r1_ovf  <= n1_sq.ovf | n1_bu1.ovf | n1_twob.ovf | n1_dtep.ovf | n1_re3.ovf
                     | n1_lap1.ovf | n1_lap2.ovf | n1_lap3.ovf
                     | n1_dif1.ovf | n1_dif2.ovf | n1_dif3.ovf;
        end
    end

    // stage 2: cube, (2+b)*u1, coupling and diffusion products, Dt*r3
    t_satq n2_cube, n2_tbu, n2_cp1, n2_cp2, n2_cp3, n2_df1, n2_df2, n2_df3, n2_dr3;
    t_q    r2_cube, r2_tbu, r2_bu1, r2_cp1, r2_cp2, r2_cp3;
    t_q    r2_df1, r2_df2, r2_df3, r2_dr3, r2_u1, r2_u2, r2_u3;
    logic  r2_ovf;

    always_comb begin
        n2_cube = mulq(r1_sq, r1_u2);
        n2_tbu  = mulq(r1_twob, r1_u1);
        n2_cp1  = mulq(r1_dtep, r1_dif1);
        n2_cp2  = mulq(r1_dtep, r1_dif2);
        n2_cp3  = mulq(r1_dtep, r1_dif3);
        n2_df1  = mulq(uq(r_g1), r1_lap1);
        n2_df2  = mulq(uq(r_g2), r1_lap2);
        n2_df3  = mulq(uq(r_g3), r1_lap3);
        n2_dr3  = mulq(uq(r_dt), r1_re3);
    end

    always_ff @(posedge i_clk) begin
        if (ld[1]) begin
            r2_cube <= n2_cube.val;
            r2_tbu  <= n2_tbu.val;
            r2_bu1  <= r1_bu1;
            r2_cp1  <= n2_cp1.val;
            r2_cp2  <= n2_cp2.val;
            r2_cp3  <= n2_cp3.val;
            r2_df1  <= n2_df1.val;
            r2_df2  <= n2_df2.val;
            r2_df3  <= n2_df3.val;
            r2_dr3  <= n2_dr3.val;
            r2_u1   <= r1_u1;
            r2_u2   <= r1_u2;
            r2_u3   <= r1_u3;
            r2_ovf  <= r1_ovf | n2_cube.ovf | n2_tbu.ovf | n2_cp1.ovf | n2_cp2.ovf
                     | n2_cp3.ovf | n2_df1.ovf | n2_df2.ovf | n2_df3.ovf | n2_dr3.ovf;
        end
    end

    // stage 3: reaction terms one and two, partial sums, species three done
    t_satq n3_re1, n3_re2, n3_nx3;
    t_q    r3_re1, r3_re2, r3_nx3;
    t_sum  r3_s1, r3_s2;
    logic  r3_ovf;

    always_comb begin
        n3_re1 = sat40(sx(r_feed_a) - sx(r2_tbu) + sx(r2_cube) + sx(r2_u3));
        n3_re2 = sat40(sx(r2_bu1) - sx(r2_cube));
        n3_nx3 = sat40(sx(r2_u3) + sx(r2_dr3) + sx(r2_cp3) + sx(r2_df3));
    end

    always_ff @(posedge i_clk) begin
        if (ld[2]) begin
            r3_re1 <= n3_re1.val;
            r3_re2 <= n3_re2.val;
            r3_nx3 <= n3_nx3.val;
            r3_s1  <= t_sum'(r2_u1) + t_sum'(r2_cp1) + t_sum'(r2_df1);
            r3_s2  <= t_sum'(r2_u2) + t_sum'(r2_cp2) + t_sum'(r2_df2);
            r3_ovf <= r2_ovf | n3_re1.ovf | n3_re2.ovf | n3_nx3.ovf;
        end
    end

    // stage 4: Dt*r1, Dt*r2
    t_satq n4_dr1, n4_dr2;
    t_q    r4_dr1, r4_dr2, r4_nx3;
    t_sum  r4_s1, r4_s2;
    logic  r4_ovf;

    always_comb begin
        n4_dr1 = mulq(uq(r_dt), r3_re1);
        n4_dr2 = mulq(uq(r_dt), r3_re2);
    end

    always_ff @(posedge i_clk) begin
        if (ld[3]) begin
            r4_dr1 <= n4_dr1.val;
            r4_dr2 <= n4_dr2.val;
            r4_nx3 <= r3_nx3;
            r4_s1  <= r3_s1;
            r4_s2  <= r3_s2;
            r4_ovf <= r3_ovf | n4_dr1.ovf | n4_dr2.ovf;
        end
    end

    // stage 5: final sums into the output register
    t_satq n5_nx1, n5_nx2;
    t_q    r5_nx1, r5_nx2, r5_nx3;
    logic  r5_ovf;

    always_comb begin
        n5_nx1 = sat40(t_wide'(r4_s1) + sx(r4_dr1));
        n5_nx2 = sat40(t_wide'(r4_s2) + sx(r4_dr2));
    end

    always_ff @(posedge i_clk) begin
        if (ld[4]) begin
            r5_nx1 <= n5_nx1.val;
            r5_nx2 <= n5_nx2.val;
            r5_nx3 <= r4_nx3;
            r5_ovf <= r4_ovf | n5_nx1.ovf | n5_nx2.ovf;
        end
    end

    assign o_out.valid      = r_vld[NSTG-1];
    assign o_out.next_one   = r5_nx1;
    assign o_out.next_two   = r5_nx2;
    assign o_out.next_three = r5_nx3;
    assign o_out.overflow   = r5_ovf;

    // checks
    logic in_acc, out_acc;
    assign in_acc  = i_in.valid && i_in.ready;
    assign out_acc = o_out.valid && o_out.ready;

    `BCE_ASSERT_IMP(a_full_stall_blocks, i_clk, i_rst_n, (&r_vld) && !o_out.ready, !i_in.ready)
    `BCE_ASSERT_NXT(a_fill_count_up, i_clk, i_rst_n, in_acc && !out_acc, $countones(r_vld) == $past($countones(r_vld)) + 1)
    `BCE_ASSERT_NXT(a_fill_count_down, i_clk, i_rst_n, out_acc && !in_acc, $countones(r_vld) + 1 == $past($countones(r_vld)))

endmodule

`default_nettype wire

FILE: dv/bce_step_checker.sv
// Checker for the Brusselator cell update: predicts each next-state result from
// the accepted requests and register writes, then compares the delivered results.
// Depends on bce_pkg and the interfaces in bce_if.sv.
module bce_step_checker import bce_pkg::*; (
    input  wire i_clk,
    input  wire i_rst_n,
    bce_in_if   i_cell,
    bce_out_if  i_next,
    bce_cfg_if  i_reg,
    output int  o_errors,
    output int  o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_q   one;
        t_q   two;
        t_q   three;
        logic ovf;
    } cell_next_t;

    localparam longint Q_HI = 64'sd2147483647;
    localparam longint Q_LO = -64'sd2147483648;
    localparam int     SHOWN_MAX = 10;

    longint     feed_a_q, feed_b_q, dt_q, ep_q, gain1_q, gain2_q, gain3_q;
    bit         sat_seen;
    cell_next_t next_q[$];
    int         fail_count = 0;

    function automatic longint clamp32(input longint v);
        if (v > Q_HI) begin
            sat_seen = 1'b1;
            return Q_HI;
        end
        if (v < Q_LO) begin
            sat_seen = 1'b1;
            return Q_LO;
        end
        return v;
    endfunction

    // exact product, add half an lsb, floor back to Q8.24
    function automatic longint qmul(input longint x, input longint y);
        longint p;
        p = x * y + (64'sd1 <<< (FRAC - 1));
        return clamp32(p >>> FRAC);
    endfunction

    function automatic longint species_next(input longint u, input longint react,
                                            input longint dtep, input longint other,
                                            input longint left, input longint right,
                                            input longint gain);
        longint drive, coup, lap, diff;
        drive = qmul(dt_q, react);
        coup  = qmul(dtep, clamp32(other - u));
        lap   = clamp32(right + left - 2 * u);
        diff  = qmul(gain, lap);
        return clamp32(u + drive + coup + diff);
    endfunction

    function automatic cell_next_t predict_next();
        longint     u1, u2, u3, twob, sq, cube, re1, re2, re3, dtep;
        cell_next_t r;
        u1 = longint'(i_cell.conc_one);
        u2 = longint'(i_cell.conc_two);
        u3 = longint'(i_cell.conc_three);
        sat_seen = 1'b0;
        twob = clamp32(longint'(Q_TWO) + feed_b_q);
        sq   = qmul(u1, u1);
        cube = qmul(sq, u2);
        re1  = clamp32(feed_a_q - qmul(twob, u1) + cube + u3);
        re2  = clamp32(qmul(feed_b_q, u1) - cube);
        re3  = clamp32(u1 - u3);
        dtep = qmul(dt_q, ep_q);
        r.one   = t_q'(species_next(u1, re1, dtep, longint'(i_cell.one_delayed_other),
                                    longint'(i_cell.one_left),
                                    longint'(i_cell.one_right), gain1_q));
        r.two   = t_q'(species_next(u2, re2, dtep, longint'(i_cell.two_delayed_other),
                                    longint'(i_cell.two_left),
                                    longint'(i_cell.two_right), gain2_q));
        r.three = t_q'(species_next(u3, re3, dtep, longint'(i_cell.three_delayed_other),
                                    longint'(i_cell.three_left),
                                    longint'(i_cell.three_right), gain3_q));
        r.ovf   = sat_seen;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        cell_next_t want;
        cell_next_t got;
        if (!i_rst_n) begin
            feed_a_q = longint'(RST_FEED_A);
            feed_b_q = longint'(RST_FEED_B);
            dt_q     = longint'(RST_TIME_STEP);
            ep_q     = longint'(RST_COUPLING);
            gain1_q  = longint'(RST_GAIN_ONE);
            gain2_q  = longint'(RST_GAIN_TWO);
            gain3_q  = longint'(RST_GAIN_THREE);
            next_q.delete();
        end else begin
            if (i_reg.valid && i_reg.ready) begin
                // unsigned registers keep 31 bits; unknown indexes are dropped
                case (i_reg.index)
                    CFG_FEED_A:          feed_a_q = longint'($signed(i_reg.data));
                    CFG_FEED_B:          feed_b_q = longint'($signed(i_reg.data));
                    CFG_TIME_STEP:       dt_q     = longint'({1'b0, i_reg.data[QW-2:0]});
                    CFG_COUPLING:        ep_q     = longint'({1'b0, i_reg.data[QW-2:0]});
                    CFG_DIFF_GAIN_ONE:   gain1_q  = longint'({1'b0, i_reg.data[QW-2:0]});
                    CFG_DIFF_GAIN_TWO:   gain2_q  = longint'({1'b0, i_reg.data[QW-2:0]});
                    CFG_DIFF_GAIN_THREE: gain3_q  = longint'({1'b0, i_reg.data[QW-2:0]});
                    default: ;
                endcase
            end
            if (i_next.valid && i_next.ready) begin
                got.one   = i_next.next_one;
                got.two   = i_next.next_two;
                got.three = i_next.next_three;
                got.ovf   = i_next.overflow;
                if (next_q.size() == 0) begin
                    fail_count++;
                    if (fail_count <= SHOWN_MAX)
                        $display("%0t: result with nothing pending: %h %h %h ovf=%b",
                                 $realtime, got.one, got.two, got.three, got.ovf);
                end else begin
                    want = next_q.pop_front();
                    if (want.one !== got.one || want.two !== got.two ||
                        want.three !== got.three || want.ovf !== got.ovf) begin
                        fail_count++;
                        if (fail_count <= SHOWN_MAX)
                            $display("%0t: mismatch exp %h %h %h ovf=%b got %h %h %h ovf=%b",
                                     $realtime, want.one, want.two, want.three, want.ovf,
                                     got.one, got.two, got.three, got.ovf);
                    end
                end
            end
            if (i_cell.valid && i_cell.ready)
                next_q.push_back(predict_next());
        end
        o_errors      <= fail_count;
        o_outstanding <= next_q.size();
    end

endmodule

FILE: dv/brusselator_cell_euler_update_tb.sv
// Top of the Brusselator cell update testbench: clock, reset, register writes,
// cell requests and result back-pressure; bce_step_checker does the checking.
// Depends on bce_pkg, bce_if.sv, the block and bce_step_checker.
module brusselator_cell_euler_update_tb import bce_pkg::*; ();
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_q conc_one;
        t_q conc_two;
        t_q conc_three;
        t_q one_left;
        t_q one_right;
        t_q two_left;
        t_q two_right;
        t_q three_left;
        t_q three_right;
        t_q one_other;
        t_q two_other;
        t_q three_other;
    } cell_req_t;

    localparam t_q               QMAX          = 32'sh7fffffff;
    localparam t_q               QMIN          = 32'sh80000000;
    localparam t_q               QONE          = 32'sh01000000;
    localparam logic [CFG_IW-1:0] CFG_SPARE    = 3'd7;
    localparam int               NUM_REGS      = 7;
    localparam int               NUM_DIRECTED  = 13;
    localparam int               NUM_PHASES    = 8;
    localparam int               PHASE_CELLS   = 170;
    localparam int               HOLD_CYCLES   = 60;
    localparam int               TAIL_CYCLES   = 20;
    localparam int               PRESSURE_PH   = 1;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   results_pending;
    bit   tx_idle_on = 1'b0;
    bit   rx_idle_on = 1'b0;
    bit   hold_req   = 1'b0;

    bce_in_if  in_ch();
    bce_out_if out_ch();
    bce_cfg_if cfg_ch();

    brusselator_cell_euler_update u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    bce_step_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cell        (in_ch),
        .i_next        (out_ch),
        .i_reg         (cfg_ch),
        .o_errors      (fail_count),
        .o_outstanding (results_pending)
    );

    always #5 i_clk = ~i_clk;

    initial begin
        #3_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // result side: random stall bursts, plus one long hold-off on request
    initial begin
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end else if (rx_idle_on && $urandom_range(0, 7) == 0) begin
                out_ch.ready = 1'b0;
                repeat ($urandom_range(1, 9)) @(negedge i_clk);
            end else begin
                out_ch.ready = 1'b1;
                @(negedge i_clk);
            end
        end
    end

    task automatic drive_cell(input cell_req_t c);
        in_ch.conc_one            = c.conc_one;
        in_ch.conc_two            = c.conc_two;
        in_ch.conc_three          = c.conc_three;
        in_ch.one_left            = c.one_left;
        in_ch.one_right           = c.one_right;
        in_ch.two_left            = c.two_left;
        in_ch.two_right           = c.two_right;
        in_ch.three_left          = c.three_left;
        in_ch.three_right         = c.three_right;
        in_ch.one_delayed_other   = c.one_other;
        in_ch.two_delayed_other   = c.two_other;
        in_ch.three_delayed_other = c.three_other;
    endtask

    // leaves valid high on return so back-to-back requests need no gap
    task automatic send_cell(input cell_req_t c);
        if (tx_idle_on && $urandom_range(0, 5) == 0) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 9)) @(negedge i_clk);
        end
        drive_cell(c);
        in_ch.valid = 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        in_ch.valid = 1'b0;
        while (results_pending != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [QW-1:0] data);
        cfg_ch.index = idx;
        cfg_ch.data  = data;
        cfg_ch.valid = 1'b1;
        do @(posedge i_clk); while (!cfg_ch.ready);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    function automatic t_q phys_conc();
        return t_q'(int'($urandom_range(0, 32'd100663296)) - 33554432);
    endfunction

    function automatic t_q near(input t_q c);
        return c + t_q'(int'($urandom_range(0, 32'd4194304)) - 2097152);
    endfunction

    function automatic t_q wild_field();
        case ($urandom_range(0, 4))
            0:       return QMAX;
            1:       return QMIN;
            2:       return '0;
            3:       return t_q'($urandom);
            default: return phys_conc();
        endcase
    endfunction

    function automatic cell_req_t directed_cell(input int k);
        cell_req_t c;
        c = '0;
        case (k)
            0: ;
            1: c = {12{QMAX}};
            2: c = {12{QMIN}};
            3: begin
                c.conc_one = QONE;  c.conc_two = 2 * QONE;  c.conc_three = QONE;
                c.one_left = QONE;  c.one_right = QONE;
                c.two_left = 2 * QONE;  c.two_right = 2 * QONE;
                c.three_left = QONE;  c.three_right = QONE;
                c.one_other = QONE;  c.two_other = 2 * QONE;  c.three_other = QONE;
            end
            4: begin
                c.conc_one = QMAX;  c.conc_two = QMAX;
            end
            5: begin
                c.conc_one = QMIN;  c.conc_two = QMIN;  c.conc_three = QMAX;
            end
            // laplacian saturating high, then low
            6: begin
                c = {12{QMAX}};
                c.conc_one = QMIN;  c.conc_two = QMIN;  c.conc_three = QMIN;
            end
            7: begin
                c = {12{QMIN}};
                c.conc_one = QMAX;  c.conc_two = QMAX;  c.conc_three = QMAX;
            end
            // difference to the other medium saturating
            8: begin
                c.conc_one = QMIN;  c.conc_two = QMIN;  c.conc_three = QMIN;
                c.one_other = QMAX;  c.two_other = QMAX;  c.three_other = QMAX;
            end
            9: begin
                c.conc_one = QMAX;  c.conc_two = QMAX;  c.conc_three = QMAX;
                c.one_other = QMIN;  c.two_other = QMIN;  c.three_other = QMIN;
            end
            10: begin
                c.conc_one = -(QONE + QONE / 2);  c.conc_two = 3 * QONE;
                c.conc_three = -2 * QONE;
                c.one_left = near(c.conc_one);  c.one_right = near(c.conc_one);
                c.two_left = near(c.conc_two);  c.two_right = near(c.conc_two);
                c.three_left = near(c.conc_three);  c.three_right = near(c.conc_three);
                c.one_other = QONE;  c.two_other = -QONE;  c.three_other = QONE / 2;
            end
            // tiny values close to the rounding step
            11: begin
                c.conc_one = 32'sd4096;  c.conc_two = -32'sd2048;  c.conc_three = 32'sd1;
                c.one_left = -32'sd1;  c.one_right = 32'sd2048;
                c.two_left = 32'sd1;  c.two_right = -32'sd4096;
                c.three_left = 32'sd8388608;  c.three_right = -32'sd8388608;
                c.one_other = -32'sd1;  c.two_other = 32'sd1;  c.three_other = -32'sd2048;
            end
            default: begin
                c.conc_one = QONE;  c.conc_two = -QONE;  c.conc_three = 0;
                c.one_left = QMAX;  c.one_right = QMIN;
                c.two_left = QMIN;  c.two_right = QMAX;
                c.three_left = QMAX;  c.three_right = QMAX;
                c.one_other = QMIN;  c.two_other = QMAX;  c.three_other = QMIN;
            end
        endcase
        return c;
    endfunction

    function automatic cell_req_t rand_cell();
        cell_req_t c;
        int        pick;
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
            c.conc_one    = phys_conc();
            c.conc_two    = phys_conc();
            c.conc_three  = phys_conc();
            c.one_left    = near(c.conc_one);
            c.one_right   = near(c.conc_one);
            c.two_left    = near(c.conc_two);
            c.two_right   = near(c.conc_two);
            c.three_left  = near(c.conc_three);
            c.three_right = near(c.conc_three);
            c.one_other   = phys_conc();
            c.two_other   = phys_conc();
            c.three_other = phys_conc();
        end else if (pick < 85) begin
            c = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        end else begin
            c = {wild_field(), wild_field(), wild_field(), wild_field(),
                 wild_field(), wild_field(), wild_field(), wild_field(),
                 wild_field(), wild_field(), wild_field(), wild_field()};
        end
        return c;
    endfunction

    // bit 31 of the unsigned registers is set at random to check it is dropped
    function automatic logic [QW-1:0] rand_reg(input t_cfg_idx idx);
        logic [QW-1:0] top_bit;
        top_bit = {$urandom_range(0, 1) == 1, {(QW-1){1'b0}}};
        case ($urandom_range(0, 9))
            0: return 32'h7fffffff;
            1: return 32'hffffffff;
            2: return 32'h80000000;
            3: return '0;
            4: return $urandom;
            default: begin
                case (idx)
                    CFG_FEED_A:    return $urandom_range(0, 32'd67108864);
                    CFG_FEED_B:    return $urandom_range(0, 32'd134217728);
                    CFG_TIME_STEP: return top_bit | $urandom_range(0, 32'd1048576);
                    CFG_COUPLING:  return top_bit | $urandom_range(0, 32'd33554432);
                    default:       return top_bit | $urandom_range(0, 32'd8388608);
                endcase
            end
        endcase
    endfunction

    initial begin
        i_rst_n      = 1'b0;
        in_ch.valid  = 1'b0;
        drive_cell('0);
        cfg_ch.valid = 1'b0;
        cfg_ch.index = '0;
        cfg_ch.data  = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset register values, then every register at an extreme
        for (int k = 0; k < NUM_DIRECTED; k++)
            send_cell(directed_cell(k));
        wait_drained();
        write_reg(CFG_FEED_A,          32'h7fffffff);
        write_reg(CFG_FEED_B,          32'h80000000);
        write_reg(CFG_TIME_STEP,       32'hffffffff);
        write_reg(CFG_COUPLING,        32'hffffffff);
        write_reg(CFG_DIFF_GAIN_ONE,   32'h7fffffff);
        write_reg(CFG_DIFF_GAIN_TWO,   32'h7fffffff);
        write_reg(CFG_DIFF_GAIN_THREE, 32'h7fffffff);
        write_reg(CFG_SPARE,           32'h12345678);
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        for (int k = 0; k < NUM_DIRECTED; k++)
            send_cell(directed_cell(k));

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            wait_drained();
            for (int r = 0; r < NUM_REGS; r++)
                write_reg(r[CFG_IW-1:0], rand_reg(t_cfg_idx'(r)));
            if ($urandom_range(0, 1) == 1)
                write_reg(CFG_SPARE, $urandom);
            // last phase runs flat out; the pressure phase keeps the sender busy
            tx_idle_on = (ph != PRESSURE_PH) && (ph != NUM_PHASES - 1) &&
                         ($urandom_range(0, 3) != 0);
            rx_idle_on = (ph != NUM_PHASES - 1) && ($urandom_range(0, 3) != 0);
            for (int n = 0; n < PHASE_CELLS; n++) begin
                if (ph == PRESSURE_PH && n == 20)
                    hold_req = 1'b1;
                send_cell(rand_cell());
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && results_pending == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
